### hw/rtl/cbc_pkg.sv
`timescale 1ns / 1ps
package cbc_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned POS_W  = 16;
  localparam int unsigned HOLD_W = 16;
  localparam int unsigned TRAV_W = 18;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 18;

  // reset values of the configuration registers
  localparam logic [HOLD_W-1:0] RESTART_HOLD_RST = 16'd10000;
  localparam logic [HOLD_W-1:0] MODE_HOLD_RST    = 16'd5000;
  localparam logic [HOLD_W-1:0] DBL_CLICK_RST    = 16'd400;
  localparam logic [HOLD_W-1:0] CAL_HOLD_RST     = 16'd5000;
  localparam logic [TRAV_W-1:0] TRAVEL_RST       = 18'd60000;

  localparam logic [POS_W-1:0] POS_CLOSED    = 16'd0;
  localparam logic [POS_W-1:0] POS_OPENED    = 16'd65535;
  localparam logic [POS_W-1:0] POSITION_HALF = 16'd32768;

  // quotient bits of the middle fraction
  localparam int unsigned FRAC_BITS = POS_W;

  localparam logic [CFG_IDX_W-1:0] CFG_RESTART_HOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_HOLD    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DBL_CLICK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_HOLD     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_TRAVEL   = 3'd4;

  typedef enum logic [2:0] {
    ACT_CLOSE_BTN = 3'd0,
    ACT_OPEN_BTN  = 3'd1,
    ACT_STOP_BTN  = 3'd2,
    ACT_UP_RELAY  = 3'd3,
    ACT_DOWN_RELAY = 3'd4,
    ACT_NET_FAIL  = 3'd5,
    ACT_NET_CFG   = 3'd6,
    ACT_NET_CONN  = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    LED_NONE  = 3'd0,
    LED_OFF   = 3'd1,
    LED_SLOW  = 3'd2,
    LED_BLINK = 3'd3,
    LED_FAST  = 3'd4
  } led_t;

  typedef struct packed {
    logic [2:0]        action;
    logic              level;
    logic [TIME_W-1:0] since_ms;
    logic [TIME_W-1:0] now_ms;
    logic              initializing;
    logic              down_relay_on;
  } in_item_t;

  typedef struct packed {
    logic              stop_motor;
    logic              load_duration;
    logic [TIME_W-1:0] duration_ms;
    logic              mark_closed;
    logic              move_request;
    logic [POS_W-1:0]  target_position;
    logic [2:0]        led_mode;
    logic              restart_request;
    logic              mode_now;
    logic              save_calibration;
    logic [POS_W-1:0]  middle_position;
  } out_item_t;

endpackage

### hw/rtl/curtain_button_calibration_control.sv
`timescale 1ns / 1ps
// curtain button and calibration control
//
// input channel: in_valid / in_stall / in_data, one button, relay or network
// event per transfer, stamped with the current and level-entry millisecond
// times. result channel: out_valid / out_stall / out_data, exactly one motor
// command word per accepted event, in order.
// configuration: cfg_we / cfg_index / cfg_data, to be written only while
// idle (the block does not enforce this); unknown indexes are dropped.
// result path: an ordinary event passes the hold state and the output register before out_valid.
// the end of a calibration run (down relay off while calibrating) runs a
// restoring divide on one shared 34-bit subtractor: a check step, one step
// per bit of the 16-bit quotient, then the hand-off; the check alone settles
// a zero travel or a middle at or past the end.
// the block takes no new event while one is in progress; in_stall is high
// until the result reaches out_data.
// a stalled result stays in the output register; the block still takes one
// new event and holds its result until the output register frees up.
// reset (rst_n low, synchronous) loads the register defaults, clears mode,
// calibration and click state, sets half travel and empties the output.
module curtain_button_calibration_control (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  cbc_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output cbc_pkg::out_item_t                 out_data,
  input  logic                               cfg_we,
  input  logic [cbc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cbc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import cbc_pkg::*;

  localparam int unsigned CNT_W = (FRAC_BITS > 1) ? $clog2(FRAC_BITS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS - 1);

  // sequencer: take event, optional divide check and bit steps, hand off
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PREP = 4'b0010,
    S_DIV  = 4'b0100,
    S_HOLD = 4'b1000
  } seq_state_t;

  seq_state_t state_r, state_nxt;

  // configuration registers
  logic [HOLD_W-1:0] restart_hold_r, mode_hold_r, dbl_click_r, cal_hold_r;
  logic [TRAV_W-1:0] def_travel_r;

  // block state
  logic              cal_r, cal_nxt;
  logic [TIME_W-1:0] mark_r, mark_nxt;
  logic [TIME_W-1:0] last_rel_r, last_rel_nxt;
  logic [POS_W-1:0]  mid_frac_r, mid_frac_nxt;
  logic              op_mode_r, op_mode_nxt;

  // divide datapath
  logic [TIME_W-1:0] rem_r, rem_nxt;
  logic [TIME_W-1:0] div_r, div_nxt;
  logic [POS_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  // result waiting for the output register, and the output register
  out_item_t res_r, res_nxt;
  out_item_t hand_off;
  out_item_t out_data_r;
  logic      out_valid_r;

  logic in_take;
  logic out_free;
  logic start_div;

  logic [TIME_W-1:0] held;
  logic [TIME_W-1:0] gap;
  logic [TIME_W-1:0] total;
  logic [TIME_W-1:0] middle;

  // shared compare / subtract unit
  logic              shift_sel;
  logic [TIME_W+1:0] cand;
  logic [TIME_W+1:0] diff;
  logic              ge;

  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign held   = in_data.now_ms - in_data.since_ms;
  assign gap    = in_data.now_ms - last_rel_r;
  assign total  = held;
  assign middle = (mark_r != '0) ? (in_data.now_ms - mark_r) : (total >> 1);

  assign shift_sel = (state_r == S_DIV);
  assign cand = shift_sel ? {1'b0, rem_r, 1'b0} : {2'b00, rem_r};
  assign diff = cand - {2'b00, div_r};
  assign ge   = !diff[TIME_W+1];

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      restart_hold_r <= RESTART_HOLD_RST;
      mode_hold_r    <= MODE_HOLD_RST;
      dbl_click_r    <= DBL_CLICK_RST;
      cal_hold_r     <= CAL_HOLD_RST;
      def_travel_r   <= TRAVEL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RESTART_HOLD: restart_hold_r <= cfg_data[HOLD_W-1:0];
        CFG_MODE_HOLD:    mode_hold_r    <= cfg_data[HOLD_W-1:0];
        CFG_DBL_CLICK:    dbl_click_r    <= cfg_data[HOLD_W-1:0];
        CFG_CAL_HOLD:     cal_hold_r     <= cfg_data[HOLD_W-1:0];
        CFG_DEF_TRAVEL:   def_travel_r   <= cfg_data[TRAV_W-1:0];
        default: ;
      endcase
    end
  end

  // event decode: all commands and state changes except the fraction
  always_comb begin
    cal_nxt      = cal_r;
    mark_nxt     = mark_r;
    last_rel_nxt = last_rel_r;
    op_mode_nxt  = op_mode_r;
    start_div    = 1'b0;
    res_nxt      = '0;

    case (action_t'(in_data.action))
      ACT_CLOSE_BTN: begin
        if (!cal_r && !in_data.initializing) begin
          res_nxt.move_request    = 1'b1;
          res_nxt.target_position = POS_CLOSED;
        end
      end
      ACT_OPEN_BTN: begin
        if (!cal_r && !in_data.initializing) begin
          res_nxt.move_request    = 1'b1;
          res_nxt.target_position = POS_OPENED;
          // long press release starts a calibration run
          if (!in_data.level && (held > {{(TIME_W-HOLD_W){1'b0}}, cal_hold_r})) begin
            mark_nxt              = '0;
            cal_nxt               = 1'b1;
            res_nxt.stop_motor    = 1'b1;
            res_nxt.load_duration = 1'b1;
            res_nxt.duration_ms   = {{(TIME_W-TRAV_W){1'b0}}, def_travel_r};
            res_nxt.mark_closed   = 1'b1;
            res_nxt.led_mode      = LED_BLINK;
          end
        end
      end
      ACT_STOP_BTN: begin
        if (!in_data.initializing) begin
          if (cal_r) begin
            // only a release while going down counts
            if (in_data.down_relay_on && !in_data.level) begin
              if (mark_r == '0) begin
                mark_nxt = in_data.now_ms;
              end else begin
                res_nxt.stop_motor = 1'b1;
              end
            end
          end else if (!in_data.level) begin
            if (held > {{(TIME_W-HOLD_W){1'b0}}, restart_hold_r}) begin
              res_nxt.restart_request = 1'b1;
            end else if (held > {{(TIME_W-HOLD_W){1'b0}}, mode_hold_r}) begin
              op_mode_nxt      = !op_mode_r;
              res_nxt.led_mode = op_mode_r ? LED_FAST : LED_SLOW;
            end else if (gap < {{(TIME_W-HOLD_W){1'b0}}, dbl_click_r}) begin
              res_nxt.move_request    = 1'b1;
              res_nxt.target_position = mid_frac_r;
            end else begin
              last_rel_nxt       = in_data.now_ms;
              res_nxt.stop_motor = 1'b1;
            end
          end else begin
            res_nxt.stop_motor = 1'b1;
          end
        end
      end
      ACT_UP_RELAY: begin
        if (!in_data.level && cal_r) begin
          res_nxt.move_request    = 1'b1;
          res_nxt.target_position = POS_CLOSED;
          res_nxt.led_mode        = LED_FAST;
        end
      end
      ACT_DOWN_RELAY: begin
        if (!in_data.level && cal_r) begin
          cal_nxt                  = 1'b0;
          start_div                = 1'b1;
          res_nxt.save_calibration = 1'b1;
          res_nxt.load_duration    = 1'b1;
          res_nxt.duration_ms      = total;
          res_nxt.mark_closed      = 1'b1;
          res_nxt.led_mode         = LED_OFF;
        end
      end
      ACT_NET_FAIL: begin
        if (!op_mode_r) begin
          op_mode_nxt      = 1'b1;
          res_nxt.led_mode = LED_SLOW;
        end
      end
      ACT_NET_CFG: begin
        if (op_mode_r) begin
          op_mode_nxt      = 1'b0;
          res_nxt.led_mode = LED_FAST;
        end
      end
      ACT_NET_CONN: begin
        res_nxt.led_mode = LED_OFF;
      end
      default: ;
    endcase

    res_nxt.mode_now        = op_mode_nxt;
    res_nxt.middle_position = mid_frac_r;
  end

  // sequencer and divide steps
  always_comb begin
    state_nxt    = state_r;
    rem_nxt      = rem_r;
    div_nxt      = div_r;
    quo_nxt      = quo_r;
    cnt_nxt      = cnt_r;
    mid_frac_nxt = mid_frac_r;

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          rem_nxt   = middle;
          div_nxt   = total;
          quo_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = start_div ? S_PREP : S_HOLD;
        end
      end
      S_PREP: begin
        // zero travel gives half, a middle at or past the end saturates
        if (div_r == '0) begin
          mid_frac_nxt = POSITION_HALF;
          state_nxt    = S_HOLD;
        end else if (ge) begin
          mid_frac_nxt = POS_OPENED;
          state_nxt    = S_HOLD;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (ge) begin
          rem_nxt = diff[TIME_W-1:0];
        end else begin
          rem_nxt = cand[TIME_W-1:0];
        end
        quo_nxt = {quo_r[POS_W-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          mid_frac_nxt = {quo_r[POS_W-2:0], ge};
          state_nxt    = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // fraction settles after the transfer, so take the live value
  always_comb begin
    hand_off                 = res_r;
    hand_off.middle_position = mid_frac_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cal_r       <= 1'b0;
      mark_r      <= '0;
      last_rel_r  <= '0;
      mid_frac_r  <= POSITION_HALF;
      op_mode_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      mid_frac_r <= mid_frac_nxt;
      if (in_take) begin
        cal_r      <= cal_nxt;
        mark_r     <= mark_nxt;
        last_rel_r <= last_rel_nxt;
        op_mode_r  <= op_mode_nxt;
      end
      if (state_r == S_HOLD && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    if (in_take) begin
      res_r <= res_nxt;
    end else if (state_r == S_HOLD && !out_free) begin
      res_r <= res_r;
    end
    if (state_r == S_HOLD && out_free) begin
      out_data_r <= hand_off;
    end
  end

  // a transferred event always leaves idle
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (state_r != S_IDLE))
    else $error("event transfer did not start the sequencer");

  // last divide step hands the result off
  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r == CNT_LAST) |=> (state_r == S_HOLD))
    else $error("divide did not finish after its last bit");

  // middle at or past total travel saturates the fraction
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PREP && div_r != '0 && ge) |=> (mid_frac_r == POS_OPENED))
    else $error("middle fraction not saturated");

  // a handed-off result shows on the output next cycle
  a_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HOLD && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result hand-off lost");

endmodule

### test/curtain_button_calibration_control_tb.sv
`timescale 1ns / 1ps
module curtain_button_calibration_control_tb;
  import cbc_pkg::*;

  // cycles with no transfer on either channel before the run is given up
  localparam int unsigned STALL_LIMIT = 5000;
  // long receiver hold-off, in cycles, so the block backs up into in_stall
  localparam int unsigned BACKUP_CYCLES = 400;
  // idle time after the last command comes back, covers the divide latency
  localparam int unsigned SETTLE_CYCLES = 25;
  localparam int unsigned ITEMS_PER_PHASE = 305;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  curtain_button_calibration_control u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // events waiting for the driver, motor commands waiting for the block
  in_item_t event_q[$];
  out_item_t command_q[$];
  int unsigned pushed_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int unsigned hold_left = 0;
  logic in_taken = 1'b0;
  logic [31:0] ms_now = '0;

  // register copies, as the block holds them
  logic [HOLD_W-1:0] hold_restart = RESTART_HOLD_RST;
  logic [HOLD_W-1:0] hold_mode = MODE_HOLD_RST;
  logic [HOLD_W-1:0] click_gap = DBL_CLICK_RST;
  logic [HOLD_W-1:0] hold_cal = CAL_HOLD_RST;
  logic [TRAV_W-1:0] travel_default = TRAVEL_RST;

  // controller state: calibration, middle mark, last stop release, fraction, mode
  logic cal_running = 1'b0;
  logic [31:0] mid_mark_ms = '0;
  logic [31:0] stop_release_ms = '0;
  logic [POS_W-1:0] mid_frac = POSITION_HALF;
  logic op_config = 1'b0;

  // a real mode change lights the led: fast back in normal, slow in configuration
  function automatic logic [2:0] enter_mode(logic m);
    if (m == op_config) return LED_NONE;
    op_config = m;
    return m ? LED_SLOW : LED_FAST;
  endfunction

  function automatic out_item_t next_command(in_item_t ev);
    out_item_t cmd;
    logic [31:0] held;
    logic [31:0] total;
    logic [31:0] middle;
    logic [47:0] quot;
    cmd = '0;
    case (action_t'(ev.action))
      ACT_CLOSE_BTN: begin
        if (!cal_running && !ev.initializing) begin
          cmd.move_request = 1'b1;
          cmd.target_position = POS_CLOSED;
        end
      end
      ACT_OPEN_BTN: begin
        if (!cal_running && !ev.initializing) begin
          cmd.move_request = 1'b1;
          cmd.target_position = POS_OPENED;
          // long open hold: travel-time calibration starts from a closed mark
          if (!ev.level && (ev.now_ms - ev.since_ms) > 32'(hold_cal)) begin
            mid_mark_ms = '0;
            cmd.stop_motor = 1'b1;
            cmd.load_duration = 1'b1;
            cmd.duration_ms = 32'(travel_default);
            cmd.mark_closed = 1'b1;
            cmd.led_mode = LED_BLINK;
            cal_running = 1'b1;
          end
        end
      end
      ACT_STOP_BTN: begin
        if (!ev.initializing) begin
          if (cal_running) begin
            // only a release with the down relay on counts; first one marks the middle
            if (ev.down_relay_on && !ev.level) begin
              if (mid_mark_ms == '0) mid_mark_ms = ev.now_ms;
              else cmd.stop_motor = 1'b1;
            end
          end else if (ev.level) begin
            cmd.stop_motor = 1'b1;
          end else begin
            held = ev.now_ms - ev.since_ms;
            if (held > 32'(hold_restart)) begin
              cmd.restart_request = 1'b1;
            end else if (held > 32'(hold_mode)) begin
              cmd.led_mode = enter_mode(!op_config);
            end else if ((ev.now_ms - stop_release_ms) < 32'(click_gap)) begin
              cmd.move_request = 1'b1;
              cmd.target_position = mid_frac;
            end else begin
              stop_release_ms = ev.now_ms;
              cmd.stop_motor = 1'b1;
            end
          end
        end
      end
      ACT_UP_RELAY: begin
        if (!ev.level && cal_running) begin
          cmd.move_request = 1'b1;
          cmd.target_position = POS_CLOSED;
          cmd.led_mode = LED_FAST;
        end
      end
      ACT_DOWN_RELAY: begin
        if (!ev.level && cal_running) begin
          total = ev.now_ms - ev.since_ms;
          middle = (mid_mark_ms != '0) ? ev.now_ms - mid_mark_ms : total >> 1;
          if (total == '0) begin
            mid_frac = POSITION_HALF;
          end else begin
            quot = {middle, 16'h0000} / {16'h0000, total};
            mid_frac = (quot > 48'h00000000FFFF) ? '1 : quot[POS_W-1:0];
          end
          cal_running = 1'b0;
          cmd.save_calibration = 1'b1;
          cmd.load_duration = 1'b1;
          cmd.duration_ms = total;
          cmd.mark_closed = 1'b1;
          cmd.led_mode = LED_OFF;
        end
      end
      ACT_NET_FAIL: cmd.led_mode = enter_mode(1'b1);
      ACT_NET_CFG: begin
        if (op_config) cmd.led_mode = enter_mode(1'b0);
      end
      ACT_NET_CONN: cmd.led_mode = LED_OFF;
      default: ;
    endcase
    cmd.mode_now = op_config;
    cmd.middle_position = mid_frac;
    return cmd;
  endfunction

  function automatic string field_diff(string name, logic [31:0] want, logic [31:0] got);
    if (want === got) return "";
    return $sformatf(" %s exp %0h got %0h", name, want, got);
  endfunction

  function automatic logic coin();
    return $urandom_range(1) == 1;
  endfunction

  function automatic logic rare_busy();
    return $urandom_range(19) == 0;
  endfunction

  task automatic push_ev(action_t act, logic lvl, logic [31:0] since, logic [31:0] now,
                         logic busy, logic down_on);
    in_item_t ev;
    ev.action = act;
    ev.level = lvl;
    ev.since_ms = since;
    ev.now_ms = now;
    ev.initializing = busy;
    ev.down_relay_on = down_on;
    event_q.push_back(ev);
    pushed_cnt++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_RESTART_HOLD: hold_restart = data[HOLD_W-1:0];
      CFG_MODE_HOLD: hold_mode = data[HOLD_W-1:0];
      CFG_DBL_CLICK: click_gap = data[HOLD_W-1:0];
      CFG_CAL_HOLD: hold_cal = data[HOLD_W-1:0];
      CFG_DEF_TRAVEL: travel_default = data[TRAV_W-1:0];
      default: ;
    endcase
  endtask

  // upper data bits above a 16-bit register are junk the block must drop,
  // and the unused indexes get random writes that must change nothing
  task automatic load_settings(logic [HOLD_W-1:0] restart_v, logic [HOLD_W-1:0] mode_v,
                               logic [HOLD_W-1:0] click_v, logic [HOLD_W-1:0] cal_v,
                               logic [TRAV_W-1:0] travel_v);
    write_reg(CFG_RESTART_HOLD, {2'($urandom), restart_v});
    write_reg(CFG_MODE_HOLD, {2'($urandom), mode_v});
    write_reg(CFG_DBL_CLICK, {2'($urandom), click_v});
    write_reg(CFG_CAL_HOLD, {2'($urandom), cal_v});
    write_reg(CFG_DEF_TRAVEL, travel_v);
    for (int u = int'(CFG_DEF_TRAVEL) + 1; u < (1 << CFG_IDX_W); u++) begin
      write_reg(u[CFG_IDX_W-1:0], 18'($urandom));
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // open hold, optional up relay end, middle marks, then the down relay end
  task automatic calibration_run();
    logic [31:0] t0;
    logic [31:0] hold;
    logic [31:0] dstart;
    logic [31:0] since;
    int unsigned marks;
    hold = 32'(hold_cal) + 32'd1 + $urandom_range(0, 3000);
    t0 = ms_now;
    push_ev(ACT_OPEN_BTN, 1'b1, t0, t0, 1'b0, coin());
    ms_now += hold;
    push_ev(ACT_OPEN_BTN, 1'b0, t0, ms_now, rare_busy(), coin());
    if (coin()) begin
      // buttons are ignored while calibrating
      ms_now += $urandom_range(100, 3000);
      push_ev(action_t'($urandom_range(ACT_OPEN_BTN)), coin(), ms_now, ms_now, 1'b0, coin());
    end
    if ($urandom_range(3) != 0) begin
      ms_now += $urandom_range(1000, 40000);
      push_ev(ACT_UP_RELAY, 1'b1, t0, ms_now, 1'b0, 1'b0);
      push_ev(ACT_UP_RELAY, 1'b0, t0, ms_now, 1'b0, 1'b0);
    end
    ms_now += $urandom_range(0, 200);
    dstart = ms_now;
    push_ev(ACT_DOWN_RELAY, 1'b1, dstart, dstart, 1'b0, 1'b1);
    marks = $urandom_range(0, 2);
    for (int m = 0; m < marks; m++) begin
      ms_now += $urandom_range(500, 30000);
      push_ev(ACT_STOP_BTN, 1'b1, ms_now, ms_now, 1'b0, 1'b1);
      push_ev(ACT_STOP_BTN, 1'b0, ms_now, ms_now, rare_busy(), $urandom_range(7) != 0);
    end
    ms_now += $urandom_range(0, 30000);
    case ($urandom_range(7))
      0: since = ms_now;
      1: since = $urandom;
      default: since = dstart;
    endcase
    push_ev(ACT_DOWN_RELAY, 1'b0, since, ms_now, rare_busy(), coin());
  endtask

  task automatic add_sequence();
    logic [31:0] t0;
    logic [31:0] hold;
    ms_now += $urandom_range(20, 4000);
    t0 = ms_now;
    case ($urandom_range(11))
      0: begin
        push_ev(ACT_CLOSE_BTN, 1'b1, t0, t0, rare_busy(), coin());
        ms_now += $urandom_range(0, 2000);
        push_ev(ACT_CLOSE_BTN, 1'b0, t0, ms_now, rare_busy(), coin());
      end
      1: begin
        push_ev(ACT_OPEN_BTN, 1'b1, t0, t0, rare_busy(), coin());
        ms_now += $urandom_range(0, hold_cal);
        push_ev(ACT_OPEN_BTN, 1'b0, t0, ms_now, rare_busy(), coin());
      end
      2, 3, 4: calibration_run();
      5, 6: begin
        // two short clicks, the gap sometimes inside the double-click window
        for (int k = 0; k < 2; k++) begin
          t0 = ms_now;
          push_ev(ACT_STOP_BTN, 1'b1, t0, t0, rare_busy(), coin());
          ms_now += $urandom_range(0, 300);
          push_ev(ACT_STOP_BTN, 1'b0, t0, ms_now, rare_busy(), coin());
          ms_now += $urandom_range(0, 2 * int'(click_gap) + 50);
        end
      end
      7: begin
        hold = 32'(hold_mode) + 32'd1 + $urandom_range(0, 3000);
        push_ev(ACT_STOP_BTN, 1'b1, t0, t0, rare_busy(), coin());
        ms_now += hold;
        push_ev(ACT_STOP_BTN, 1'b0, t0, ms_now, rare_busy(), coin());
      end
      8: begin
        hold = 32'(hold_restart) + 32'd1 + $urandom_range(0, 5000);
        ms_now += hold;
        push_ev(ACT_STOP_BTN, 1'b0, t0, ms_now, rare_busy(), coin());
      end
      9: begin
        push_ev(action_t'($urandom_range(ACT_NET_FAIL, ACT_NET_CONN)), coin(), $urandom,
                ms_now, rare_busy(), coin());
      end
      10: begin
        // fully random event
        push_ev(action_t'($urandom_range(ACT_NET_CONN)), coin(), $urandom, $urandom,
                coin(), coin());
      end
      default: begin
        // clock jump anywhere in the 32-bit range, wrap included
        ms_now = $urandom;
        push_ev(ACT_STOP_BTN, 1'b0, ms_now - $urandom_range(0, 20000), ms_now,
                rare_busy(), coin());
      end
    endcase
  endtask

  // every event has come back and the block has had time to settle
  task automatic drain();
    while (accepted_cnt != pushed_cnt || command_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // driver: a new event or an idle cycle only once the last transfer is done
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (event_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= event_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // predict at the input transfer, in transfer order
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      command_q.push_back(next_command(in_data));
      accepted_cnt++;
    end
    in_taken <= rst_n && in_valid && !in_stall;
  end

  // receiver stall: random, or a long hold-off on request
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = BACKUP_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= $urandom_range(99) < recv_idle_pct;
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    string diffs;
    if (rst_n && out_valid && !out_stall) begin
      if (command_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result %h", out_data);
      end else begin
        want = command_q.pop_front();
        diffs = {field_diff("stop_motor", want.stop_motor, out_data.stop_motor),
                 field_diff("load_duration", want.load_duration, out_data.load_duration),
                 field_diff("duration_ms", want.duration_ms, out_data.duration_ms),
                 field_diff("mark_closed", want.mark_closed, out_data.mark_closed),
                 field_diff("move_request", want.move_request, out_data.move_request),
                 field_diff("target_position", want.target_position,
                            out_data.target_position),
                 field_diff("led_mode", want.led_mode, out_data.led_mode),
                 field_diff("restart_request", want.restart_request,
                            out_data.restart_request),
                 field_diff("mode_now", want.mode_now, out_data.mode_now),
                 field_diff("save_calibration", want.save_calibration,
                            out_data.save_calibration),
                 field_diff("middle_position", want.middle_position,
                            out_data.middle_position)};
        if (diffs != "") begin
          fail_count++;
          if (fail_count <= 10) $display("mismatch at %0t:%s", $realtime, diffs);
        end
      end
    end
  end

  // watchdog on cycles with no transfer at all
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0] t;
    int unsigned base;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 35;
    recv_idle_pct = 87;

    // directed events at the reset register values
    t = 32'd20000;
    push_ev(ACT_CLOSE_BTN, 1'b1, t, t, 1'b0, 1'b0);
    push_ev(ACT_CLOSE_BTN, 1'b0, t, t + 300, 1'b1, 1'b1);        // ignored while initializing
    push_ev(ACT_OPEN_BTN, 1'b1, t + 400, t + 400, 1'b0, 1'b0);
    push_ev(ACT_OPEN_BTN, 1'b0, t + 400, t + 500, 1'b0, 1'b0);
    push_ev(ACT_NET_CFG, 1'b0, '0, t + 600, 1'b0, 1'b0);         // normal mode: no effect
    push_ev(ACT_NET_FAIL, 1'b1, '0, t + 610, 1'b0, 1'b0);
    push_ev(ACT_NET_FAIL, 1'b0, '0, t + 620, 1'b0, 1'b0);        // already in configuration
    push_ev(ACT_NET_CFG, 1'b1, '0, t + 630, 1'b0, 1'b0);
    push_ev(ACT_NET_CONN, 1'b0, '0, t + 640, 1'b0, 1'b0);
    push_ev(ACT_STOP_BTN, 1'b1, t + 1000, t + 1000, 1'b0, 1'b0);
    push_ev(ACT_STOP_BTN, 1'b0, t + 1000, t + 1100, 1'b0, 1'b0);
    push_ev(ACT_STOP_BTN, 1'b0, t + 1250, t + 1300, 1'b0, 1'b0);  // double click
    push_ev(ACT_STOP_BTN, 1'b0, t + 2000, t + 8000, 1'b0, 1'b0);  // mode toggle
    push_ev(ACT_STOP_BTN, 1'b0, t + 9000, t + 15000, 1'b0, 1'b1); // and back
    push_ev(ACT_STOP_BTN, 1'b0, t + 16000, t + 26001, 1'b0, 1'b0);
    push_ev(ACT_STOP_BTN, 1'b0, '0, '1, 1'b0, 1'b1);             // longest possible hold
    push_ev(ACT_OPEN_BTN, 1'b0, t + 30000, t + 35001, 1'b0, 1'b1); // calibration starts
    push_ev(ACT_CLOSE_BTN, 1'b1, t + 36000, t + 36000, 1'b0, 1'b0);
    push_ev(ACT_UP_RELAY, 1'b0, t + 35001, t + 40000, 1'b0, 1'b0);
    push_ev(ACT_STOP_BTN, 1'b0, '0, '0, 1'b0, 1'b1);             // mark at time zero
    push_ev(ACT_STOP_BTN, 1'b0, 32'd300, 32'd300, 1'b0, 1'b0);   // down relay off: ignored
    push_ev(ACT_STOP_BTN, 1'b0, 32'd300, 32'd300, 1'b0, 1'b1);
    push_ev(ACT_STOP_BTN, 1'b0, 32'd400, 32'd400, 1'b0, 1'b1);   // already marked: stop
    push_ev(ACT_DOWN_RELAY, 1'b0, 32'd500, 32'd1000, 1'b0, 1'b1); // middle past total
    push_ev(ACT_OPEN_BTN, 1'b0, 32'd2000, 32'd7001, 1'b0, 1'b0);
    push_ev(ACT_DOWN_RELAY, 1'b0, 32'd7001, 32'd7001, 1'b0, 1'b0); // zero total
    drain();

    ms_now = 32'd10000;
    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        send_idle_pct = 87;
        recv_idle_pct = 35;
      end else if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        1: load_settings('0, '0, '0, '0, '0);
        3: load_settings('1, '1, '1, '1, '1);
        5: load_settings(RESTART_HOLD_RST, MODE_HOLD_RST, DBL_CLICK_RST, CAL_HOLD_RST,
                         TRAVEL_RST);
        default: load_settings(16'($urandom_range(3000, 20000)),
                               16'($urandom_range(500, 2500)),
                               16'($urandom_range(100, 1500)),
                               16'($urandom_range(200, 8000)),
                               18'($urandom));
      endcase
      base = pushed_cnt;
      while (pushed_cnt - base < ITEMS_PER_PHASE) add_sequence();
      // back up the block while the driver keeps offering events
      if (p == 0 || p == 4) hold_req++;
      drain();
    end

    if (command_q.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
